[sv/egcd_pkg.sv]
package egcd_pkg;

   localparam int FIELD_BITS     = 31;
   localparam int GCD_BITS       = 31;
   localparam int COEF_BITS      = 32;
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 96;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_SUB   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] coef_smaller;
      logic [COEF_BITS-1:0] coef_larger;
      logic [GCD_BITS-1:0]  gcd_value;
   } result_type;

endpackage

[sv/egcd_step.sv]
module egcd_step #(
   parameter int OB = 31
) (
   input  logic [OB-1:0]                  r0,
   input  logic [OB-1:0]                  r1,
   input  logic [egcd_pkg::COEF_BITS-1:0] s0,
   input  logic [egcd_pkg::COEF_BITS-1:0] s1,
   input  logic [egcd_pkg::COEF_BITS-1:0] t0,
   input  logic [egcd_pkg::COEF_BITS-1:0] t1,
   input  logic [$clog2(OB)-1:0]          k,
   output logic                           can_grow,
   output logic                           fits,
   output logic [OB-1:0]                  r0_post,
   output logic [egcd_pkg::COEF_BITS-1:0] s0_post,
   output logic [egcd_pkg::COEF_BITS-1:0] t0_post
);
   import egcd_pkg::*;

   localparam int KW = $clog2(OB);

   logic [OB-1:0]        r1_sh;
   logic [COEF_BITS-1:0] s1_sh;
   logic [COEF_BITS-1:0] t1_sh;
   logic [KW:0]          k_up;

   // divisor r1 shifted by k, one quotient bit per use
   always_comb begin
      k_up     = {1'b0, k} + (KW+1)'(1);
      can_grow = ({1'b0, k} < (KW+1)'(OB-1)) && (r1 <= (r0 >> k_up));
      r1_sh    = r1 << k;
      s1_sh    = s1 << k;
      t1_sh    = t1 << k;
      fits     = r1_sh <= r0;
      r0_post  = fits ? (r0 - r1_sh) : r0;
      s0_post  = fits ? (s0 - s1_sh) : s0;
      t0_post  = fits ? (t0 - t1_sh) : t0;
   end

endmodule

[sv/egcd_core.sv]
module egcd_core #(
   parameter int OB = 31
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [egcd_pkg::FIELD_BITS-1:0]  operand_a,
   input  logic [egcd_pkg::FIELD_BITS-1:0]  operand_b,
   output logic                             ready,
   output logic                             res_valid,
   input  logic                             res_taken,
   output egcd_pkg::result_type             result
);
   import egcd_pkg::*;

   localparam int KW = $clog2(OB);

   state_type            state_ff, state_in;
   logic [OB-1:0]        r0_ff, r0_in, r1_ff, r1_in;
   logic [COEF_BITS-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [COEF_BITS-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [KW-1:0]        k_ff, k_in;
   result_type           res_ff, res_in;

   logic [OB-1:0]        a_m, b_m, big, small_op;
   logic                 can_grow, fits;
   logic [OB-1:0]        r0_post;
   logic [COEF_BITS-1:0] s0_post, t0_post;

   egcd_step #(.OB(OB)) u_step (
      .r0       (r0_ff),
      .r1       (r1_ff),
      .s0       (s0_ff),
      .s1       (s1_ff),
      .t0       (t0_ff),
      .t1       (t1_ff),
      .k        (k_ff),
      .can_grow (can_grow),
      .fits     (fits),
      .r0_post  (r0_post),
      .s0_post  (s0_post),
      .t0_post  (t0_post)
   );

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign result    = res_ff;

   always_comb begin
      a_m      = operand_a[OB-1:0];
      b_m      = operand_b[OB-1:0];
      big      = (a_m < b_m) ? b_m : a_m;
      small_op = (a_m < b_m) ? a_m : b_m;

      state_in = state_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      k_in     = k_ff;
      res_in   = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (small_op == '0) begin
                  res_in.gcd_value    = GCD_BITS'(big);
                  res_in.coef_larger  = COEF_BITS'(1);
                  res_in.coef_smaller = '0;
                  state_in            = ST_DONE;
               end else begin
                  r0_in    = big;
                  r1_in    = small_op;
                  s0_in    = COEF_BITS'(1);
                  s1_in    = '0;
                  t0_in    = '0;
                  t1_in    = COEF_BITS'(1);
                  k_in     = '0;
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN, ST_SUB: begin
            if ((state_ff == ST_ALIGN) && can_grow) begin
               k_in = k_ff + KW'(1);
            end else begin
               r0_in = r0_post;
               s0_in = s0_post;
               t0_in = t0_post;
               if (k_ff != '0) begin
                  k_in     = k_ff - KW'(1);
                  state_in = ST_SUB;
               end else if (r0_post == '0) begin
                  res_in.gcd_value    = GCD_BITS'(r1_ff);
                  res_in.coef_larger  = s1_ff;
                  res_in.coef_smaller = t1_ff;
                  state_in            = ST_DONE;
               end else begin
                  // quotient done: rotate remainder and coefficients
                  r0_in    = r1_ff;
                  r1_in    = r0_post;
                  s0_in    = s1_ff;
                  s1_in    = s0_post;
                  t0_in    = t1_ff;
                  t1_in    = t0_post;
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

endmodule

[sv/extended_gcd_unit.sv]
// Extended gcd unit: one request gives one response with the gcd of the
// two operands and Bezout coefficients for the larger and smaller operand.
// Request channel req_*: a transfer loads both operands; req_tready is high
// only while the sequencer is idle, so one pair is in work at a time.
// Response channel rsp_*: held in an output register until rsp_tready.
// A new request is taken while that response still waits.
// Each quotient step of Euclid runs on one shared shift-subtract unit:
// the divisor is first shifted up, then one quotient bit is taken per step
// on the way down. A result goes from the sequencer's result register to
// the response register. A zero operand skips the quotient steps.
// If rsp_tready stays low, the finished result parks in the sequencer and
// no further request is taken until the response register frees.
// Synchronous reset returns the sequencer to idle and drops rsp_tvalid.
module extended_gcd_unit #(
   parameter int OPERAND_BITS = 31
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // operand_a [30:0], operand_b [61:31], zero [63:62]
   input  logic [egcd_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // gcd_value [30:0], coef_larger [62:31], coef_smaller [94:63], zero [95]
   output logic [egcd_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);
   import egcd_pkg::*;

   localparam int OB = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;

   logic       core_ready, res_valid, load;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   egcd_core #(.OB(OB)) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid),
      .operand_a (req_tdata[FIELD_BITS-1:0]),
      .operand_b (req_tdata[2*FIELD_BITS-1:FIELD_BITS]),
      .ready     (core_ready),
      .res_valid (res_valid),
      .res_taken (load),
      .result    (result)
   );

   assign req_tready = core_ready;
   assign load       = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_data_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
